// ----- design/dwc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dwc_pkg;

    // Widths fixed by the item and register formats.
    localparam int CMD_WIDTH      = 2;
    localparam int SLOT_IDX_WIDTH = 2;
    localparam int MASK_WIDTH     = 4;
    localparam int LIMIT_WIDTH    = 16;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_NUM_SLOTS = 4;
    localparam int DEFAULT_AGE_WIDTH = 16;

    // Configuration port.
    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH  = 2;

    localparam logic [REG_IDX_WIDTH-1:0] REG_DEBOUNCE    = 2'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_MAX_DEFER   = 2'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_ALWAYS_MASK = 2'd2;

    localparam logic [LIMIT_WIDTH-1:0] DEBOUNCE_RESET  = 16'd1000;
    localparam logic [LIMIT_WIDTH-1:0] MAX_DEFER_RESET = 16'd5000;
    localparam logic [MASK_WIDTH-1:0]  ALWAYS_MASK_RESET = 4'd1;

    // Command codes.
    localparam logic [CMD_WIDTH-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_FLUSH   = 2'd2;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] debounce_ticks;
        logic [LIMIT_WIDTH-1:0] max_defer_ticks;
        logic [MASK_WIDTH-1:0]  always_flush_mask;
    } cfg_t;

    typedef struct packed {
        logic req;
        logic tick;
        logic flush;
    } slot_ctl_t;

endpackage

`default_nettype wire

// ----- design/debounced_write_coalescer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: a command beat accepted on s_ is held in the input register and evaluated there,
// and its result (ticks and flushes only) is registered in the result register for m_.
// Throughput: one command per cycle, held back only when the result register is full
// and m_ready is low; all slots age and compare in parallel in that single cycle.
// Reset (aresetn, synchronous, active low) clears every pending mark and age, empties
// both registers and loads the limits with 1000, 5000 and a flush mask of slot 0.

module debounced_write_coalescer #(
    parameter int NUM_SLOTS = dwc_pkg::DEFAULT_NUM_SLOTS,
    parameter int AGE_WIDTH = dwc_pkg::DEFAULT_AGE_WIDTH
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // Command channel.
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [dwc_pkg::CMD_WIDTH-1:0]        s_cmd,
    input  wire logic [dwc_pkg::SLOT_IDX_WIDTH-1:0]   s_slot,

    // Result channel.
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic      [dwc_pkg::MASK_WIDTH-1:0]       m_due_mask,
    output logic                                      m_from_flush,

    // Configuration port.
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [dwc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [dwc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [dwc_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                      pready
);

    dwc_pkg::cfg_t cfg;

    // Input register: holds one command beat until it is evaluated.
    logic                                in_valid_reg, in_valid_next;
    logic [dwc_pkg::CMD_WIDTH-1:0]       in_cmd_reg;
    logic [dwc_pkg::SLOT_IDX_WIDTH-1:0]  in_slot_reg;

    // Result register: decouples the result from the downstream ready.
    logic                                out_valid_reg, out_valid_next;
    logic [dwc_pkg::MASK_WIDTH-1:0]      out_mask_reg, out_mask_next;
    logic                                out_flush_reg;

    logic is_req, is_tick, is_flush, makes_result, advance, s_accept;
    logic [NUM_SLOTS-1:0] slot_due;

    dwc_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign is_req       = in_valid_reg && (in_cmd_reg == dwc_pkg::CMD_REQUEST);
    assign is_tick      = in_valid_reg && (in_cmd_reg == dwc_pkg::CMD_TICK);
    assign is_flush     = in_valid_reg && (in_cmd_reg == dwc_pkg::CMD_FLUSH);
    assign makes_result = is_tick || is_flush;

    // The held beat retires when it needs no result slot, or when the result
    // register is empty or being drained this cycle. The unused command code
    // retires with no effect at all.
    assign advance  = in_valid_reg && (!makes_result || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    // One timer per slot. Requests can only name slots that the index field can
    // reach, so any slots beyond that range never become pending.
    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
        dwc_pkg::slot_ctl_t ctl;
        if (i < (1 << dwc_pkg::SLOT_IDX_WIDTH)) begin : g_addr
            assign ctl.req = advance && is_req &&
                             (in_slot_reg == dwc_pkg::SLOT_IDX_WIDTH'(i));
        end else begin : g_noaddr
            assign ctl.req = 1'b0;
        end
        assign ctl.tick  = advance && is_tick;
        assign ctl.flush = advance && is_flush;

        dwc_slot_timer #(
            .AGE_WIDTH (AGE_WIDTH)
        ) u_slot (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .cfg     (cfg),
            .due     (slot_due[i])
        );
    end

    // Mask bits only exist for slots that are present; a flush also reports
    // the always-write slots whether or not they are pending.
    for (genvar b = 0; b < dwc_pkg::MASK_WIDTH; b++) begin : g_mask
        if (b < NUM_SLOTS) begin : g_live
            assign out_mask_next[b] = slot_due[b] |
                                      (is_flush & cfg.always_flush_mask[b]);
        end else begin : g_dead
            assign out_mask_next[b] = 1'b0;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && makes_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg  <= s_cmd;
            in_slot_reg <= s_slot;
        end
        if (advance && makes_result) begin
            out_mask_reg  <= out_mask_next;
            out_flush_reg <= is_flush;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_due_mask   = out_mask_reg;
    assign m_from_flush = out_flush_reg;

endmodule

`default_nettype wire

// ----- design/dwc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dwc_cfg_regs (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [dwc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [dwc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [dwc_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                      pready,
    output dwc_pkg::cfg_t                             cfg
);

    logic [dwc_pkg::LIMIT_WIDTH-1:0] debounce_reg;
    logic [dwc_pkg::LIMIT_WIDTH-1:0] max_defer_reg;
    logic [dwc_pkg::MASK_WIDTH-1:0]  always_mask_reg;
    logic [dwc_pkg::REG_IDX_WIDTH-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[dwc_pkg::APB_ADDR_WIDTH-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg    <= dwc_pkg::DEBOUNCE_RESET;
            max_defer_reg   <= dwc_pkg::MAX_DEFER_RESET;
            always_mask_reg <= dwc_pkg::ALWAYS_MASK_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                dwc_pkg::REG_DEBOUNCE: begin
                    debounce_reg <= pwdata[dwc_pkg::LIMIT_WIDTH-1:0];
                end
                dwc_pkg::REG_MAX_DEFER: begin
                    max_defer_reg <= pwdata[dwc_pkg::LIMIT_WIDTH-1:0];
                end
                dwc_pkg::REG_ALWAYS_MASK: begin
                    always_mask_reg <= pwdata[dwc_pkg::MASK_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            dwc_pkg::REG_DEBOUNCE: begin
                prdata[dwc_pkg::LIMIT_WIDTH-1:0] = debounce_reg;
            end
            dwc_pkg::REG_MAX_DEFER: begin
                prdata[dwc_pkg::LIMIT_WIDTH-1:0] = max_defer_reg;
            end
            dwc_pkg::REG_ALWAYS_MASK: begin
                prdata[dwc_pkg::MASK_WIDTH-1:0] = always_mask_reg;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.debounce_ticks    = debounce_reg;
    assign cfg.max_defer_ticks   = max_defer_reg;
    assign cfg.always_flush_mask = always_mask_reg;

endmodule

`default_nettype wire

// ----- design/dwc_slot_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dwc_slot_timer #(
    parameter int AGE_WIDTH = dwc_pkg::DEFAULT_AGE_WIDTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dwc_pkg::slot_ctl_t ctl,
    input  wire dwc_pkg::cfg_t     cfg,
    output logic                   due
);

    // Compare width covers both the age range and the limit registers, so a
    // limit above the largest age is simply never reached.
    localparam int CMP_WIDTH = (AGE_WIDTH > dwc_pkg::LIMIT_WIDTH) ?
                               AGE_WIDTH : dwc_pkg::LIMIT_WIDTH;

    logic                 pending_reg, pending_next;
    logic [AGE_WIDTH-1:0] first_age_reg, first_age_next;
    logic [AGE_WIDTH-1:0] last_age_reg, last_age_next;
    logic [AGE_WIDTH-1:0] first_aged, last_aged;
    logic                 limit_hit;

    assign first_aged = (&first_age_reg) ? first_age_reg
                                         : first_age_reg + AGE_WIDTH'(1);
    assign last_aged  = (&last_age_reg)  ? last_age_reg
                                         : last_age_reg + AGE_WIDTH'(1);

    assign limit_hit =
        (CMP_WIDTH'(last_aged)  >= CMP_WIDTH'(cfg.debounce_ticks)) ||
        (CMP_WIDTH'(first_aged) >= CMP_WIDTH'(cfg.max_defer_ticks));

    assign due = pending_reg & ((ctl.tick & limit_hit) | ctl.flush);

    always_comb begin
        pending_next   = pending_reg;
        first_age_next = first_age_reg;
        last_age_next  = last_age_reg;
        if (ctl.req) begin
            if (!pending_reg) begin
                pending_next   = 1'b1;
                first_age_next = '0;
            end
            last_age_next = '0;
        end else if (ctl.tick) begin
            first_age_next = first_aged;
            last_age_next  = last_aged;
            if (due) begin
                pending_next = 1'b0;
            end
        end else if (ctl.flush) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            first_age_reg <= '0;
            last_age_reg  <= '0;
        end else begin
            pending_reg   <= pending_next;
            first_age_reg <= first_age_next;
            last_age_reg  <= last_age_next;
        end
    end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // The unused command code has no name in the package; the block must ignore it.
    localparam logic [dwc_pkg::CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;
    localparam int SLOTS = dwc_pkg::DEFAULT_NUM_SLOTS;

    typedef struct packed {
        logic [dwc_pkg::CMD_WIDTH-1:0]      cmd;
        logic [dwc_pkg::SLOT_IDX_WIDTH-1:0] slot;
    } command_t;

    typedef struct packed {
        logic [dwc_pkg::MASK_WIDTH-1:0] due_mask;
        logic                           from_flush;
    } due_report_t;

    // Every input starts at a known value, with reset held from time zero.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [dwc_pkg::CMD_WIDTH-1:0] s_cmd = '0;
    logic [dwc_pkg::SLOT_IDX_WIDTH-1:0] s_slot = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [dwc_pkg::MASK_WIDTH-1:0] m_due_mask;
    logic m_from_flush;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [dwc_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [dwc_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [dwc_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic pready;

    debounced_write_coalescer DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_slot       (s_slot),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_due_mask   (m_due_mask),
        .m_from_flush (m_from_flush),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial forever #5 aclk = ~aclk;

    // Commands waiting to be offered, and the due reports still owed by the block.
    command_t    cmd_backlog[$];
    due_report_t due_q[$];

    // The testbench's own copy of the coalescer: limits, pending marks and both ages.
    logic [dwc_pkg::LIMIT_WIDTH-1:0] cfg_debounce   = dwc_pkg::DEBOUNCE_RESET;
    logic [dwc_pkg::LIMIT_WIDTH-1:0] cfg_max_defer  = dwc_pkg::MAX_DEFER_RESET;
    logic [dwc_pkg::MASK_WIDTH-1:0]  cfg_flush_mask = dwc_pkg::ALWAYS_MASK_RESET;
    logic                            slot_pending [SLOTS];
    logic [15:0]                     first_age [SLOTS];
    logic [15:0]                     last_age [SLOTS];

    // When clear, both sides run flat out.
    bit gaps_on = 1'b1;

    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int flush_reports = 0;
    int due_bits = 0;
    int config_writes = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_pending[i] = 1'b0;
            first_age[i] = '0;
            last_age[i] = '0;
        end
    end

    // Apply one accepted command to the model and queue the report it owes, if any.
    function void coalesce_command(input logic [dwc_pkg::CMD_WIDTH-1:0] cmd,
                                   input logic [dwc_pkg::SLOT_IDX_WIDTH-1:0] slot);
        due_report_t rep;
        rep = '0;
        case (cmd)
            dwc_pkg::CMD_REQUEST: begin
                if (!slot_pending[slot]) begin
                    slot_pending[slot] = 1'b1;
                    first_age[slot] = '0;
                end
                last_age[slot] = '0;
            end
            dwc_pkg::CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (first_age[i] != 16'hFFFF) first_age[i] = first_age[i] + 16'd1;
                    if (last_age[i] != 16'hFFFF) last_age[i] = last_age[i] + 16'd1;
                    if (slot_pending[i] && (last_age[i] >= cfg_debounce ||
                                            first_age[i] >= cfg_max_defer)) begin
                        slot_pending[i] = 1'b0;
                        rep.due_mask[i] = 1'b1;
                    end
                end
                due_q.push_back(rep);
            end
            dwc_pkg::CMD_FLUSH: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_pending[i]) rep.due_mask[i] = 1'b1;
                    slot_pending[i] = 1'b0;
                end
                rep.due_mask = rep.due_mask | cfg_flush_mask;
                rep.from_flush = 1'b1;
                due_q.push_back(rep);
            end
            default: begin
            end
        endcase
    endfunction

    // Command driver. A beat is handed to the model at the edge where it is taken,
    // and the next one is put up in the same step so valid never drops between
    // back-to-back beats. Gaps are inserted only when the channel is free.
    always @(posedge aclk) begin : drive_commands
        command_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                coalesce_command(s_cmd, s_slot);
                beats_in++;
            end
            if (!s_valid || s_ready) begin
                if (cmd_backlog.size() != 0 && (!gaps_on || $urandom_range(99) >= 33)) begin
                    nxt = cmd_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= nxt.cmd;
                    s_slot <= nxt.slot;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result sink. Besides random stalls it holds off once for a long stretch while
    // commands are still queued, which fills the block and pushes back on s_ready.
    always @(posedge aclk) begin : drive_result_ready
        static int hold_left = 0;
        static int taken = 0;
        static bit hold_done = 1'b0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) taken++;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && taken >= 300 && cmd_backlog.size() > 40) begin
                hold_done = 1'b1;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !gaps_on || $urandom_range(99) >= 33;
            end
        end
    end

    // Result checker: every beat taken from the block is matched against the oldest
    // report the model still owes.
    always @(posedge aclk) begin : check_results
        due_report_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (m_from_flush) flush_reports++;
            due_bits += $countones(m_due_mask);
            if (due_q.size() == 0) begin
                $display("%0t: result beat with nothing owed: due_mask %h from_flush %b",
                         $time, m_due_mask, m_from_flush);
                errors++;
            end else begin
                want = due_q.pop_front();
                if (m_due_mask !== want.due_mask) begin
                    $display("%0t: due_mask expected %h actual %h",
                             $time, want.due_mask, m_due_mask);
                    errors++;
                end
                if (m_from_flush !== want.from_flush) begin
                    $display("%0t: from_flush expected %b actual %b",
                             $time, want.from_flush, m_from_flush);
                    errors++;
                end
            end
        end
    end

    // One register write: setup cycle, then access cycle. The register takes the
    // value at the edge that ends the access cycle, and so does the model.
    task write_reg(input logic [dwc_pkg::REG_IDX_WIDTH-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dwc_pkg::APB_ADDR_WIDTH'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            dwc_pkg::REG_DEBOUNCE:    cfg_debounce = value[dwc_pkg::LIMIT_WIDTH-1:0];
            dwc_pkg::REG_MAX_DEFER:   cfg_max_defer = value[dwc_pkg::LIMIT_WIDTH-1:0];
            dwc_pkg::REG_ALWAYS_MASK: cfg_flush_mask = value[dwc_pkg::MASK_WIDTH-1:0];
            default: begin
            end
        endcase
        config_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task set_limits(input int debounce, input int max_defer, input int flush_mask);
        write_reg(dwc_pkg::REG_DEBOUNCE, debounce);
        write_reg(dwc_pkg::REG_MAX_DEFER, max_defer);
        write_reg(dwc_pkg::REG_ALWAYS_MASK, flush_mask);
    endtask

    function void queue_cmd(input logic [dwc_pkg::CMD_WIDTH-1:0] cmd,
                            input logic [dwc_pkg::SLOT_IDX_WIDTH-1:0] slot);
        command_t c;
        c.cmd = cmd;
        c.slot = slot;
        cmd_backlog.push_back(c);
    endfunction

    // Wait until every command has been taken and every report has come back, then
    // give the block time to settle, since a trailing request makes no report.
    task wait_drained();
        @(posedge aclk);
        while (cmd_backlog.size() != 0 || s_valid || due_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Random traffic: mostly requests and ticks so slots go pending and come due,
    // now and then a flush, and rarely the unused code, which is only noise.
    task random_traffic(input int count);
        int pick;
        logic [dwc_pkg::SLOT_IDX_WIDTH-1:0] rnd_slot;
        @(negedge aclk);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            rnd_slot = dwc_pkg::SLOT_IDX_WIDTH'($urandom_range(3));
            if (pick < 45)
                queue_cmd(dwc_pkg::CMD_REQUEST, rnd_slot);
            else if (pick < 89)
                queue_cmd(dwc_pkg::CMD_TICK, rnd_slot);
            else if (pick < 97)
                queue_cmd(dwc_pkg::CMD_FLUSH, rnd_slot);
            else
                queue_cmd(CMD_UNUSED, rnd_slot);
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limits: fill every slot, re-request a pending slot, feed the unused
        // code, then a tick with nothing due and two flushes, the second one clean.
        @(negedge aclk);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd0);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd1);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd2);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd3);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd3);
        queue_cmd(CMD_UNUSED, 2'd2);
        queue_cmd(CMD_UNUSED, 2'd1);
        queue_cmd(dwc_pkg::CMD_TICK, 2'd3);
        queue_cmd(dwc_pkg::CMD_FLUSH, 2'd0);
        queue_cmd(dwc_pkg::CMD_FLUSH, 2'd3);
        queue_cmd(dwc_pkg::CMD_TICK, 2'd0);
        wait_drained();

        // Short limits and an empty flush mask. Slot 1 is kept quiet until the
        // debounce fires; slot 2 keeps being re-requested until it hits max deferral.
        set_limits(2, 3, 0);
        @(negedge aclk);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd1);
        queue_cmd(dwc_pkg::CMD_TICK, 2'd0);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd1);
        queue_cmd(dwc_pkg::CMD_TICK, 2'd0);
        queue_cmd(dwc_pkg::CMD_TICK, 2'd0);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd2);
        queue_cmd(dwc_pkg::CMD_TICK, 2'd0);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd2);
        queue_cmd(dwc_pkg::CMD_TICK, 2'd0);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd2);
        queue_cmd(dwc_pkg::CMD_TICK, 2'd0);
        queue_cmd(dwc_pkg::CMD_REQUEST, 2'd3);
        queue_cmd(dwc_pkg::CMD_FLUSH, 2'd0);
        wait_drained();

        set_limits(3, 8, 15);
        random_traffic(150);

        // Smallest legal limits, then zero limits: every pending slot is due on the
        // very next tick.
        set_limits(1, 1, 0);
        random_traffic(120);
        set_limits(0, 0, 5);
        random_traffic(100);

        // Largest limits: nothing is ever due on a tick, only flushes report.
        set_limits(16'hFFFF, 16'hFFFF, 10);
        random_traffic(100);

        // A long stretch with both sides running flat out.
        set_limits(5, 20, 6);
        gaps_on = 1'b0;
        random_traffic(150);
        gaps_on = 1'b1;

        for (int p = 0; p < 3; p++) begin
            set_limits($urandom_range(12, 2), $urandom_range(40, 4), $urandom_range(15));
            random_traffic(120);
        end

        $display("Covered %0d command beats and %0d result beats (%0d from flushes, %0d due bits),",
                 beats_in, beats_out, flush_reports, due_bits);
        $display("over %0d register writes spanning zero, smallest and largest limits.",
                 config_writes);
        if (errors == 0) begin
            $display("debounced_write_coalescer: match");
        end else begin
            $display("debounced_write_coalescer: mismatch");
        end
        $finish;
    end

    // Safety net far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("Timed out with %0d commands queued and %0d reports owed.",
                 cmd_backlog.size(), due_q.size());
        $display("debounced_write_coalescer: mismatch");
        $finish;
    end

endmodule
